/* src/ddrc_pkg.sv */
// shared types, constants and helper functions of the decimal digit range counter
// used by every module of the block; depends on nothing else

package ddrc_pkg;

  localparam int unsigned BOUND_W    = 30;
  localparam int unsigned OCC_W      = 30;
  // a 30-bit value has at most ten decimal positions
  localparam int unsigned NUM_POS    = 10;
  localparam int unsigned BCD_W      = 4 * NUM_POS;
  localparam int unsigned NUM_DIGITS = 10;
  // one position term, never above bound + 1
  localparam int unsigned TERM_W     = BOUND_W + 1;
  // running difference of two counts, each below ten times the bound
  localparam int unsigned ACC_W      = BOUND_W + 5;
  localparam int unsigned CNT_W      = $clog2(BOUND_W);

  localparam logic [3:0]       LAST_DIGIT = 4'd9;
  localparam logic [OCC_W-1:0] OCC_MAX    = '1;

  typedef logic [BOUND_W-1:0] bound_t;
  typedef logic [3:0]         bcd_digit_t;

  typedef struct packed {
    logic [BOUND_W-1:0] bound_first;
    logic [BOUND_W-1:0] bound_second;
  } in_t;

  typedef struct packed {
    logic [3:0]       digit;
    logic [OCC_W-1:0] occurrences;
    logic             last;
  } out_t;

  // view of one number at the decimal position under work
  typedef struct packed {
    bcd_digit_t cur;
    bound_t     ap;     // value above the position, times the position weight
    bound_t     below;  // value below the position
    bound_t     p;      // position weight
  } pos_t;

  typedef struct packed {
    logic       load;
    logic       conv;
    logic       walk;
    logic [3:0] pos;
  } unit_ctrl_t;

  typedef struct packed {
    logic clear;
    logic step;
  } lane_ctrl_t;

  function automatic bound_t pow10(logic [3:0] idx);
    bound_t r;
    unique case (idx)
      4'd0:    r = BOUND_W'(1);
      4'd1:    r = BOUND_W'(10);
      4'd2:    r = BOUND_W'(100);
      4'd3:    r = BOUND_W'(1000);
      4'd4:    r = BOUND_W'(10000);
      4'd5:    r = BOUND_W'(100000);
      4'd6:    r = BOUND_W'(1000000);
      4'd7:    r = BOUND_W'(10000000);
      4'd8:    r = BOUND_W'(100000000);
      4'd9:    r = BOUND_W'(1000000000);
      default: r = '0;
    endcase
    return r;
  endfunction

  // largest value with the given number of decimal digits
  function automatic logic [63:0] bound_lim(int unsigned digits);
    logic [63:0] p;
    p = 64'd1;
    for (int k = 0; k < 19; k++) begin
      if (k < digits) p = p * 64'd10;
    end
    return p - 64'd1;
  endfunction

endpackage

/* src/ddrc_num_unit.sv */
// one number: bit-serial binary to bcd conversion, then a walk over its decimal
// positions from the top, one digit per cycle; depends on ddrc_pkg

module ddrc_num_unit (
  input  logic                clk_i,
  input  ddrc_pkg::unit_ctrl_t ctrl_i,
  input  ddrc_pkg::bound_t    value_i,
  output ddrc_pkg::pos_t      pos_o
);
  import ddrc_pkg::*;

  bound_t           bin_q;
  logic [BCD_W-1:0] bcd_q;
  bound_t           ap_q;
  bound_t           rem_q;

  logic [BCD_W-1:0]   bcd_adj;
  bcd_digit_t         cur;
  bound_t             p_cur;
  bound_t             p_next;
  logic [BOUND_W+3:0] prod_cur;
  logic [BOUND_W+3:0] prod_next;
  bound_t             below;

  // add three to every digit of five or more before the shift
  always_comb begin
    for (int i = 0; i < NUM_POS; i++) begin
      bcd_adj[4*i +: 4] = (bcd_q[4*i +: 4] >= 4'd5) ? bcd_q[4*i +: 4] + 4'd3
                                                     : bcd_q[4*i +: 4];
    end
  end

  assign cur       = bcd_q[BCD_W-1 -: 4];
  assign p_cur     = pow10(ctrl_i.pos);
  assign p_next    = (ctrl_i.pos == 4'd0) ? '0 : pow10(ctrl_i.pos - 4'd1);
  // both products never exceed the number itself
  assign prod_cur  = {{BOUND_W{1'b0}}, cur} * {4'b0, p_cur};
  assign prod_next = {{BOUND_W{1'b0}}, cur} * {4'b0, p_next};
  assign below     = rem_q - prod_cur[BOUND_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      bin_q <= value_i;
      bcd_q <= '0;
      ap_q  <= '0;
      rem_q <= value_i;
    end else if (ctrl_i.conv) begin
      bcd_q <= {bcd_adj[BCD_W-2:0], bin_q[BOUND_W-1]};
      bin_q <= {bin_q[BOUND_W-2:0], 1'b0};
    end else if (ctrl_i.walk) begin
      bcd_q <= {bcd_q[BCD_W-5:0], 4'b0};
      rem_q <= below;
      ap_q  <= ap_q + prod_next[BOUND_W-1:0];
    end
  end

  assign pos_o = '{cur: cur, ap: ap_q, below: below, p: p_cur};

endmodule

/* src/ddrc_digit_lanes.sv */
// ten digit lanes: each adds the position term of the high bound and takes off
// that of the low bound less one; depends on ddrc_pkg

module ddrc_digit_lanes (
  input  logic                  clk_i,
  input  ddrc_pkg::lane_ctrl_t  ctrl_i,
  input  ddrc_pkg::pos_t        pos_hi_i,
  input  ddrc_pkg::pos_t        pos_lo_i,
  input  logic [3:0]            rd_idx_i,
  output logic [ddrc_pkg::OCC_W-1:0] occ_o
);
  import ddrc_pkg::*;

  logic [ACC_W-1:0] acc_q [NUM_DIGITS];
  logic [ACC_W-1:0] sel;

  function automatic logic [TERM_W-1:0] term(pos_t x, logic [3:0] d);
    logic [TERM_W-1:0] ap;
    logic [TERM_W-1:0] p;
    logic [TERM_W-1:0] below;
    logic [TERM_W-1:0] r;
    ap    = {1'b0, x.ap};
    p     = {1'b0, x.p};
    below = {1'b0, x.below};
    if (d == 4'd0) begin
      // zero counts only below a nonzero leading part
      if (x.ap == '0) r = '0;
      else if (x.cur != 4'd0) r = ap;
      else r = ap - p + below + TERM_W'(1);
    end else begin
      if (x.cur > d) r = ap + p;
      else if (x.cur == d) r = ap + below + TERM_W'(1);
      else r = ap;
    end
    return r;
  endfunction

  for (genvar g = 0; g < NUM_DIGITS; g++) begin : g_lane
    localparam logic [3:0] D = 4'(g);
    always_ff @(posedge clk_i) begin
      if (ctrl_i.clear) begin
        acc_q[g] <= '0;
      end else if (ctrl_i.step) begin
        acc_q[g] <= acc_q[g] + ACC_W'(term(pos_hi_i, D)) - ACC_W'(term(pos_lo_i, D));
      end
    end
  end

  assign sel   = acc_q[rd_idx_i];
  assign occ_o = (sel > ACC_W'(OCC_MAX)) ? OCC_MAX : sel[OCC_W-1:0];

endmodule

/* src/decimal_digit_range_counter.sv */
// top level of the decimal digit range counter: control, bound ordering, output register
// depends on ddrc_pkg, ddrc_num_unit and ddrc_digit_lanes
//
//   channel  handshake               payload      per transaction
//   in       in_valid_i/in_stall_o   in_data_i    two bounds, either order
//   out      out_valid_o/out_stall_i out_data_o   one digit count, ten per input
//
// without an output stall an input goes through accept, ordering, bit-serial binary to
// bcd conversion, one step per decimal position and one result per digit;
// the conversion, one binary bit per cycle, is the longest of these steps
// reset clears only the control state and the output valid flag; there is no clearing pass
// an output stall holds the result sequence; the next input is taken as soon as
// the last result of the previous one sits in the output register

module decimal_digit_range_counter #(
  parameter int unsigned DECIMAL_DIGITS = 9
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  ddrc_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output ddrc_pkg::out_t out_data_o
);
  import ddrc_pkg::*;

  localparam logic [63:0] BoundLim = bound_lim(DECIMAL_DIGITS);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_ORDER = 5'b00010,
    S_CONV  = 5'b00100,
    S_WALK  = 5'b01000,
    S_EMIT  = 5'b10000
  } state_e;

  state_e           state_q, state_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  bound_t           a_q, b_q;
  out_t             out_q;
  logic             out_valid_q, out_valid_d;

  logic       in_accept;
  logic       out_load;
  logic       a_lt_b;
  bound_t     hi, lo_m1;
  unit_ctrl_t unit_ctrl;
  lane_ctrl_t lane_ctrl;
  pos_t       pos_hi, pos_lo;
  logic [OCC_W-1:0] occ;

  // zero goes to one, anything past the largest allowed value is clamped
  function automatic bound_t fix_bound(bound_t v);
    bound_t r;
    if (v == '0) r = BOUND_W'(1);
    else if ({{(64-BOUND_W){1'b0}}, v} > BoundLim) r = BoundLim[BOUND_W-1:0];
    else r = v;
    return r;
  endfunction

  assign in_stall_o = (state_q != S_IDLE);
  assign in_accept  = in_valid_i && (state_q == S_IDLE);

  // ordering happens in the cycle after the transaction, on registered bounds
  assign a_lt_b = (a_q < b_q);
  assign hi     = a_lt_b ? b_q : a_q;
  assign lo_m1  = (a_lt_b ? a_q : b_q) - BOUND_W'(1);

  // one result leaves the lanes whenever the output register is free
  assign out_load = (state_q == S_EMIT) && (!out_valid_q || !out_stall_i);

  assign unit_ctrl = '{load: (state_q == S_ORDER), conv: (state_q == S_CONV),
                       walk: (state_q == S_WALK), pos: cnt_q[3:0]};
  assign lane_ctrl = '{clear: (state_q == S_ORDER), step: (state_q == S_WALK)};

  ddrc_num_unit u_hi (
    .clk_i   (clk_i),
    .ctrl_i  (unit_ctrl),
    .value_i (hi),
    .pos_o   (pos_hi)
  );

  ddrc_num_unit u_lo (
    .clk_i   (clk_i),
    .ctrl_i  (unit_ctrl),
    .value_i (lo_m1),
    .pos_o   (pos_lo)
  );

  ddrc_digit_lanes u_lanes (
    .clk_i    (clk_i),
    .ctrl_i   (lane_ctrl),
    .pos_hi_i (pos_hi),
    .pos_lo_i (pos_lo),
    .rd_idx_i (cnt_q[3:0]),
    .occ_o    (occ)
  );

  // sequencer: conversion counts bits up, walk counts positions down,
  // emission counts digits up
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    unique case (state_q)
      S_IDLE: begin
        if (in_accept) state_d = S_ORDER;
      end
      S_ORDER: begin
        state_d = S_CONV;
        cnt_d   = '0;
      end
      S_CONV: begin
        if (cnt_q == CNT_W'(BOUND_W - 1)) begin
          state_d = S_WALK;
          cnt_d   = CNT_W'(NUM_POS - 1);
        end else begin
          cnt_d = cnt_q + CNT_W'(1);
        end
      end
      S_WALK: begin
        if (cnt_q == '0) begin
          state_d = S_EMIT;
        end else begin
          cnt_d = cnt_q - CNT_W'(1);
        end
      end
      S_EMIT: begin
        if (out_load) begin
          if (cnt_q[3:0] == LAST_DIGIT) begin
            state_d = S_IDLE;
            cnt_d   = '0;
          end else begin
            cnt_d = cnt_q + CNT_W'(1);
          end
        end
      end
      default: begin
        state_d = S_IDLE;
        cnt_d   = '0;
      end
    endcase
  end

  always_comb begin
    if (out_load) out_valid_d = 1'b1;
    else if (!out_stall_i) out_valid_d = 1'b0;
    else out_valid_d = out_valid_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      a_q <= fix_bound(in_data_i.bound_first);
      b_q <= fix_bound(in_data_i.bound_second);
    end
    if (out_load) begin
      out_q <= '{digit: cnt_q[3:0], occurrences: occ, last: (cnt_q[3:0] == LAST_DIGIT)};
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* src/ddrc_checker.sv */
// port-level checks of the decimal digit range counter and the bind that attaches them
// depends on ddrc_pkg and decimal_digit_range_counter

module ddrc_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           in_valid_i,
  input logic           in_stall_o,
  input ddrc_pkg::in_t  in_data_i,
  input logic           out_valid_o,
  input logic           out_stall_i,
  input ddrc_pkg::out_t out_data_o
);
  import ddrc_pkg::*;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result changed");

  // a stalled input transaction holds
  a_in_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_stall_o |=> in_valid_i && $stable(in_data_i))
    else $error("stalled input changed");

  // one transaction at a time on the input
  a_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> in_stall_o)
    else $error("input taken while busy");

  // last marks digit nine and nothing else
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last == (out_data_o.digit == LAST_DIGIT)))
    else $error("last flag does not match digit");

  // results follow without a gap, digit by digit
  a_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !out_data_o.last
      |=> out_valid_o && (out_data_o.digit == $past(out_data_o.digit) + 4'd1))
    else $error("digit sequence broken");

endmodule

bind decimal_digit_range_counter ddrc_checker u_ddrc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
